// ===== rtl/iee_pkg.sv =====
// ============================================================================
// Infix expression evaluator package
// Shared constants, token and status codes, and the types that pass between
// the sequencer and the shared multiply/divide unit.
// ============================================================================
package iee_pkg;

   // Word width of every value in the datapath.
   localparam int DATA_W = 64;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_STACK_DEPTH = 8;
   localparam int DEFAULT_FRAC_BITS   = 32;

   // Saturation limits of a signed word.
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Token commands.
   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_APPLY = 2'd1,
      CMD_OPEN  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   // Operators.
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_TOO_DEEP = 2'd2,
      STATUS_BAD_SEQ  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP,
      ST_APPLY,
      ST_WAIT,
      ST_RESP
   } ev_state_type;

   // Multiply/divide unit states.
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_PACK
   } md_state_type;

   // One saved nesting level: outer value, outer term and the flags/operator.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] term;
      logic [3:0]        flags_op;
   } stack_entry_type;

   // Request from the sequencer to the multiply/divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } md_req_type;

   // Response from the multiply/divide unit.
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } md_rsp_type;

endpackage

// ===== rtl/iee_muldiv.sv =====
// ============================================================================
// Shared multiply/divide unit
// Signed fixed-point multiply (shift-add, one bit a cycle) and divide
// (restoring, one quotient bit a cycle) over one shared 65-bit adder, with
// a final saturating pack of the magnitude and sign.
// ============================================================================
module iee_muldiv
   import iee_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  md_req_type        md_req,
   input  logic [DATA_W-1:0] md_a,
   input  logic [DATA_W-1:0] md_b,
   output md_rsp_type        md_rsp
);

   // Dividend width: the shifted magnitude never has more significant bits.
   localparam int QW = DATA_W + FRAC_BITS;
   localparam int CW = $clog2(QW);

   md_state_type      md_state_ff, md_state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [QW-1:0]     wq_ff, wq_in;
   logic              neg_ff, neg_in;
   logic              div_ff, div_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              done_ff, done_in;

   logic [DATA_W-1:0] a_mag, b_mag;
   logic [DATA_W:0]   add_a, add_b;
   logic              add_cin;
   logic [DATA_W+1:0] add_sum;
   logic              add_carry;
   logic [127:0]      prod_shift, quot_ext, pack_sel;
   logic              pack_hi_nz;
   logic [DATA_W-1:0] pack_lo;

   // Operand magnitudes at start.
   assign a_mag = md_a[DATA_W-1] ? (~md_a + DATA_W'(1)) : md_a;
   assign b_mag = md_b[DATA_W-1] ? (~md_b + DATA_W'(1)) : md_b;

   // The shared adder: a conditional add for multiply, a trial subtract for divide.
   always_comb begin
      if (md_state_ff == MD_DIV) begin
         add_a   = {acc_ff, wq_ff[QW-1]};
         add_b   = ~{1'b0, mcand_ff};
         add_cin = 1'b1;
      end else begin
         add_a   = {1'b0, acc_ff};
         add_b   = wq_ff[0] ? {1'b0, mcand_ff} : '0;
         add_cin = 1'b0;
      end
   end

   assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (DATA_W+2)'(add_cin);
   assign add_carry = add_sum[DATA_W+1];

   // Magnitude before packing: the scaled product or the quotient.
   assign prod_shift = {acc_ff, wq_ff[DATA_W-1:0]} >> FRAC_BITS;
   assign quot_ext   = 128'(wq_ff);
   assign pack_sel   = div_ff ? quot_ext : prod_shift;
   assign pack_hi_nz = |pack_sel[127:DATA_W];
   assign pack_lo    = pack_sel[DATA_W-1:0];

   // Next state.
   always_comb begin
      md_state_in = md_state_ff;
      unique case (md_state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               md_state_in = md_req.is_div ? MD_DIV : MD_MUL;
            end
         end
         MD_MUL, MD_DIV: begin
            if (cnt_ff == '0) begin
               md_state_in = MD_PACK;
            end
         end
         MD_PACK: md_state_in = MD_IDLE;
         default: md_state_in = MD_IDLE;
      endcase
   end

   // Datapath updates for each state.
   always_comb begin
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      wq_in     = wq_ff;
      neg_in    = neg_ff;
      div_in    = div_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (md_state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               acc_in   = '0;
               neg_in   = md_a[DATA_W-1] ^ md_b[DATA_W-1];
               div_in   = md_req.is_div;
               if (md_req.is_div) begin
                  mcand_in = b_mag;
                  wq_in    = QW'(a_mag) << FRAC_BITS;
                  cnt_in   = CW'(QW - 1);
               end else begin
                  mcand_in = a_mag;
                  wq_in    = QW'(b_mag);
                  cnt_in   = CW'(DATA_W - 1);
               end
            end
         end
         MD_MUL: begin
            acc_in              = add_sum[DATA_W:1];
            wq_in[DATA_W-1:0]   = {add_sum[0], wq_ff[DATA_W-1:1]};
            cnt_in              = cnt_ff - CW'(1);
         end
         MD_DIV: begin
            acc_in = add_carry ? add_sum[DATA_W-1:0] : add_a[DATA_W-1:0];
            wq_in  = {wq_ff[QW-2:0], add_carry};
            cnt_in = cnt_ff - CW'(1);
         end
         MD_PACK: begin
            // Saturate the magnitude to the signed range and apply the sign.
            if (neg_ff) begin
               result_in = (pack_hi_nz || pack_lo > SAT_MIN) ? SAT_MIN
                                                            : (~pack_lo + DATA_W'(1));
            end else begin
               result_in = (pack_hi_nz || pack_lo > SAT_MAX) ? SAT_MAX : pack_lo;
            end
            done_in = 1'b1;
         end
         default: done_in = 1'b0;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         md_state_ff <= MD_IDLE;
         done_ff     <= 1'b0;
      end else begin
         md_state_ff <= md_state_in;
         done_ff     <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      wq_ff     <= wq_in;
      neg_ff    <= neg_in;
      div_ff    <= div_in;
      result_ff <= result_in;
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = result_ff;

endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// ============================================================================
// Infix expression evaluator
// Evaluates a token stream of begin, operator, open-group and close tokens
// in signed fixed point, with multiply/divide precedence and nested groups.
// ============================================================================
// Usage:
//   The request channel (req_valid/req_ready) carries one token word:
//   req_command, req_op and req_operand. The response channel
//   (rsp_valid/rsp_ready) carries one word, rsp_value and rsp_status, when an
//   expression ends at its outer close token or fails (divide by zero, too
//   many open groups, or a token out of sequence); the block then returns to
//   no open expression. Other tokens give no response word.
//   One token is processed at a time; req_ready is high only when the block
//   is idle. A begin or open token passes through dispatch only; an
//   add/subtract also passes through apply, and a close of an inner group
//   first pops the outer level and then applies its operator. Multiply and
//   divide wait on the shared multiply/divide unit, which retires one
//   product or quotient bit a cycle. The response word of an outer close or
//   an error is registered and held until it is taken.
//   While a response word waits on rsp_ready, no new token is taken.
//   Reset clears the sequencer and leaves no expression open; the group
//   stack needs no clearing since each level is written before it is read.
// ============================================================================
module infix_expression_evaluator
   import iee_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int FRAC_BITS   = DEFAULT_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [1:0]               req_op,
   input  logic signed [DATA_W-1:0] req_operand,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [1:0]               rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NW = $clog2(STACK_DEPTH + 1);

   ev_state_type      state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] operand_ff, operand_in;
   logic [DATA_W-1:0] num_ff, num_in;
   logic [DATA_W-1:0] rv_ff, rv_in;
   logic [DATA_W-1:0] lt_ff, lt_in;
   logic              saw_ff, saw_in;
   logic              lwa_ff, lwa_in;
   logic              active_ff, active_in;
   logic [NW-1:0]     nest_ff, nest_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   stack_entry_type   stack_mem [STACK_DEPTH];
   stack_entry_type   rd_ff;
   stack_entry_type   wr_entry;
   logic              mem_we;
   logic [AW-1:0]     wr_idx, rd_idx;

   md_req_type        md_req;
   md_rsp_type        md_rsp;

   logic [DATA_W-1:0] as_b, as_res, as_b_eff, as_sum;
   logic              as_sub, as_ovf;
   logic              room, div_zero, is_addsub;
   logic              finish;
   logic [DATA_W-1:0] fin_value;
   status_type        fin_status;

   assign room      = nest_ff < NW'(STACK_DEPTH);
   assign div_zero  = (op_ff == OP_DIV) && (num_ff == '0);
   assign is_addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);

   // Operand selection for the saturating adder: add/sub token, undo of the
   // last term, or redo with the rescaled term.
   always_comb begin
      if (state_ff == ST_WAIT) begin
         as_b   = md_rsp.result;
         as_sub = !lwa_ff;
      end else if (state_ff == ST_APPLY && !is_addsub) begin
         as_b   = lt_ff;
         as_sub = lwa_ff;
      end else begin
         as_b   = num_ff;
         as_sub = (op_ff == OP_SUB);
      end
   end

   // Saturating add/subtract of the running value.
   assign as_b_eff = as_sub ? ~as_b : as_b;
   assign as_sum   = rv_ff + as_b_eff + DATA_W'(as_sub);
   assign as_ovf   = (rv_ff[DATA_W-1] == as_b_eff[DATA_W-1]) &&
                     (as_sum[DATA_W-1] != rv_ff[DATA_W-1]);
   assign as_res   = as_ovf ? (rv_ff[DATA_W-1] ? SAT_MIN : SAT_MAX) : as_sum;

   // Shared multiply/divide unit.
   iee_muldiv #(
      .FRAC_BITS(FRAC_BITS)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .md_req(md_req),
      .md_a  (saw_ff ? lt_ff : rv_ff),
      .md_b  (num_ff),
      .md_rsp(md_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (cmd_ff)
               CMD_BEGIN: state_in = active_ff ? ST_RESP : ST_IDLE;
               CMD_APPLY: state_in = active_ff ? ST_APPLY : ST_RESP;
               CMD_OPEN:  state_in = (active_ff && room) ? ST_IDLE : ST_RESP;
               CMD_CLOSE: state_in = (active_ff && nest_ff != '0) ? ST_POP : ST_RESP;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_POP: state_in = ST_APPLY;
         ST_APPLY: begin
            if (is_addsub) begin
               state_in = ST_IDLE;
            end else if (div_zero) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and stack control for each state.
   always_comb begin
      cmd_in        = cmd_ff;
      op_in         = op_ff;
      operand_in    = operand_ff;
      num_in        = num_ff;
      rv_in         = rv_ff;
      lt_in         = lt_ff;
      saw_in        = saw_ff;
      lwa_in        = lwa_ff;
      active_in     = active_ff;
      nest_in       = nest_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      md_req        = '0;
      finish        = 1'b0;
      fin_value     = '0;
      fin_status    = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = cmd_type'(req_command);
               op_in      = op_type'(req_op);
               operand_in = req_operand;
            end
         end
         ST_DISPATCH: begin
            unique case (cmd_ff)
               CMD_BEGIN: begin
                  if (active_ff) begin
                     finish     = 1'b1;
                     fin_status = STATUS_BAD_SEQ;
                  end else begin
                     rv_in     = operand_ff;
                     lt_in     = '0;
                     saw_in    = 1'b0;
                     lwa_in    = 1'b0;
                     active_in = 1'b1;
                     nest_in   = '0;
                  end
               end
               CMD_APPLY: begin
                  if (!active_ff) begin
                     finish     = 1'b1;
                     fin_status = STATUS_BAD_SEQ;
                  end else begin
                     num_in = operand_ff;
                  end
               end
               CMD_OPEN: begin
                  if (!active_ff) begin
                     finish     = 1'b1;
                     fin_status = STATUS_BAD_SEQ;
                  end else if (!room) begin
                     finish     = 1'b1;
                     fin_status = STATUS_TOO_DEEP;
                  end else begin
                     // Push the outer level and start the group.
                     mem_we  = 1'b1;
                     nest_in = nest_ff + NW'(1);
                     rv_in   = operand_ff;
                     lt_in   = '0;
                     saw_in  = 1'b0;
                     lwa_in  = 1'b0;
                  end
               end
               CMD_CLOSE: begin
                  if (!active_ff) begin
                     finish     = 1'b1;
                     fin_status = STATUS_BAD_SEQ;
                  end else if (nest_ff == '0) begin
                     finish     = 1'b1;
                     fin_value  = rv_ff;
                     fin_status = STATUS_OK;
                  end else begin
                     // The group value becomes the operand of its operator.
                     nest_in = nest_ff - NW'(1);
                     num_in  = rv_ff;
                  end
               end
               default: finish = 1'b1;
            endcase
         end
         ST_POP: begin
            rv_in  = rd_ff.value;
            lt_in  = rd_ff.term;
            saw_in = rd_ff.flags_op[0];
            lwa_in = rd_ff.flags_op[1];
            op_in  = op_type'(rd_ff.flags_op[3:2]);
         end
         ST_APPLY: begin
            if (is_addsub) begin
               rv_in  = as_res;
               lt_in  = num_ff;
               saw_in = 1'b1;
               lwa_in = (op_ff == OP_ADD);
            end else if (div_zero) begin
               finish     = 1'b1;
               fin_status = STATUS_DIV_ZERO;
            end else begin
               // Take the last term back out while it is rescaled.
               md_req.start  = 1'b1;
               md_req.is_div = (op_ff == OP_DIV);
               if (saw_ff) begin
                  rv_in = as_res;
               end
            end
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               if (saw_ff) begin
                  lt_in = md_rsp.result;
                  rv_in = as_res;
               end else begin
                  rv_in = md_rsp.result;
               end
            end
         end
         ST_RESP: finish = 1'b0;
         default: finish = 1'b0;
      endcase

      // A response word closes the expression.
      if (finish) begin
         rv_in         = '0;
         lt_in         = '0;
         saw_in        = 1'b0;
         lwa_in        = 1'b0;
         active_in     = 1'b0;
         nest_in       = '0;
         rsp_value_in  = fin_value;
         rsp_status_in = fin_status;
      end
   end

   // Group stack: one write port at the current level, one registered read
   // port at the level below it.
   assign wr_idx            = nest_ff[AW-1:0];
   assign rd_idx            = AW'(nest_ff - NW'(1));
   assign wr_entry.value    = rv_ff;
   assign wr_entry.term     = lt_ff;
   assign wr_entry.flags_op = {op_ff, lwa_ff, saw_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= wr_entry;
      end
      rd_ff <= stack_mem[rd_idx];
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rv_ff     <= '0;
         lt_ff     <= '0;
         saw_ff    <= 1'b0;
         lwa_ff    <= 1'b0;
         active_ff <= 1'b0;
         nest_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         lt_ff     <= lt_in;
         saw_ff    <= saw_in;
         lwa_ff    <= lwa_in;
         active_ff <= active_in;
         nest_ff   <= nest_in;
      end
      cmd_ff        <= cmd_in;
      op_ff         <= op_in;
      operand_ff    <= operand_in;
      num_ff        <= num_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/iee_checker.sv =====
// ============================================================================
// Infix expression evaluator port checker
// Watches the top-level ports for the one-token-at-a-time behavior and the
// form of response words.
// ============================================================================
module iee_checker
   import iee_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_value,
   input logic [1:0]        rsp_status
);

   // A stalled response word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // No token is taken while a response word is pending.
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response word is pending");

   // After a token is taken the block is busy and has no response yet.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after taking a token");

   // Failed expressions report a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_value == '0)
      else $error("error response with nonzero value");

   // A response word is given once: rsp_valid drops after it is taken.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response word repeated");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);
